// ----- sv/urdd_pkg.sv -----
// Shared types, constants and helper functions for the ultrasonic range display drive.
`default_nettype none

package urdd_pkg;

  // Measurement phases, one-hot
  typedef enum logic [4:0] {
    PH_IDLE      = 5'b00001,
    PH_TRIG_LOW  = 5'b00010,
    PH_TRIG_HIGH = 5'b00100,
    PH_WAIT_RISE = 5'b01000,
    PH_MEASURE   = 5'b10000
  } phase_e;

  // Configuration register indexes
  localparam logic [2:0] REG_TIMEOUT   = 3'd0;
  localparam logic [2:0] REG_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_LEFT      = 3'd2;
  localparam logic [2:0] REG_RIGHT     = 3'd3;
  localparam logic [2:0] REG_TRIG_LOW  = 3'd4;
  localparam logic [2:0] REG_TRIG_HIGH = 3'd5;

  // Register defaults
  localparam logic [15:0] TIMEOUT_RST   = 16'd65000;
  localparam logic [7:0]  THRESHOLD_RST = 8'd10;
  localparam logic [7:0]  LEFT_RST      = 8'd127;
  localparam logic [7:0]  RIGHT_RST     = 8'd255;
  localparam logic [7:0]  TRIG_LOW_RST  = 8'd16;
  localparam logic [7:0]  TRIG_HIGH_RST = 8'd156;

  // ticks*64/58 reaches 256 at 232 ticks; below that it is (ticks*9040) >> 13
  localparam logic [15:0] CM_SAT_TICKS = 16'd232;
  localparam logic [13:0] CM_RECIP     = 14'd9040;

  localparam logic [6:0] SEG_ZERO = 7'h3F;

  typedef struct packed {
    logic [3:0] hundreds;
    logic [3:0] tens;
    logic [3:0] ones;
  } bcd_t;

  typedef struct packed {
    logic       trigger_level;
    logic       done_res;
    logic [7:0] distance_cm;
    logic [6:0] seg_ones;
    logic [6:0] seg_tens;
    logic [6:0] seg_hundreds;
    logic [6:0] seg_thousands;
    logic [7:0] left_motor_duty;
    logic [7:0] right_motor_duty;
  } result_t;

  function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
    logic [6:0] pat;
    begin
      case (digit)
        4'd0:    pat = 7'h3F;
        4'd1:    pat = 7'h06;
        4'd2:    pat = 7'h5B;
        4'd3:    pat = 7'h4F;
        4'd4:    pat = 7'h66;
        4'd5:    pat = 7'h6D;
        4'd6:    pat = 7'h7D;
        4'd7:    pat = 7'h27;
        4'd8:    pat = 7'h7F;
        4'd9:    pat = 7'h67;
        default: pat = 7'h00;
      endcase
      return pat;
    end
  endfunction

  function automatic logic [7:0] ticks_to_cm(input logic [15:0] ticks);
    logic [20:0] prod;
    logic [7:0]  cm;
    begin
      prod = 21'(ticks[7:0]) * 21'(CM_RECIP);
      if (ticks >= CM_SAT_TICKS) begin
        cm = 8'hFF;
      end else begin
        cm = prod[20:13];
      end
      return cm;
    end
  endfunction

  function automatic bcd_t to_bcd(input logic [7:0] d);
    logic [1:0]  hund;
    logic [6:0]  rem;
    logic [14:0] tprod;
    logic [3:0]  tens;
    logic [6:0]  tens10;
    logic [6:0]  ones;
    bcd_t        res;
    begin
      if (d >= 8'd200) begin
        hund = 2'd2;
        rem  = 7'(d - 8'd200);
      end else if (d >= 8'd100) begin
        hund = 2'd1;
        rem  = 7'(d - 8'd100);
      end else begin
        hund = 2'd0;
        rem  = d[6:0];
      end
      // rem < 100: (rem*205) >> 11 is rem/10
      tprod        = 15'(rem) * 15'd205;
      tens         = tprod[14:11];
      tens10       = 7'(tens) * 7'd10;
      ones         = rem - tens10;
      res.hundreds = 4'(hund);
      res.tens     = tens;
      res.ones     = ones[3:0];
      return res;
    end
  endfunction

endpackage

`default_nettype wire

// ----- sv/ultrasonic_range_display_drive.sv -----
// A result enters the output register, or the skid register while the output is stalled,
// when its tick request is accepted. Throughput: one tick per cycle while the input is
// not stalled; each tick is a single pass from the state registers through the phase logic
// and the cm/digit conversion into the result register. A skid register holds a second
// result, so input stalls only when both are full. Reset: idle phase, tick count and held
// distance zero, registers at defaults, no result pending.
`default_nettype none

module ultrasonic_range_display_drive (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tick requests
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        echo_level_i,
  input  wire logic        start_request_i,
  // results
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             trigger_level_o,
  output logic             done_res_o,
  output logic [7:0]       distance_cm_o,
  output logic [6:0]       seg_ones_o,
  output logic [6:0]       seg_tens_o,
  output logic [6:0]       seg_hundreds_o,
  output logic [6:0]       seg_thousands_o,
  output logic [7:0]       left_motor_duty_o,
  output logic [7:0]       right_motor_duty_o,
  // configuration writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  logic [15:0] timeout_q;
  logic [7:0]  threshold_q;
  logic [7:0]  left_duty_q;
  logic [7:0]  right_duty_q;
  logic [7:0]  trig_low_q;
  logic [7:0]  trig_high_q;

  urdd_pkg::phase_e phase_q, phase_d;
  logic [15:0]      count_q, count_d;
  logic [7:0]       held_q, held_d;
  logic             done;
  logic [15:0]      count_inc;

  logic             in_accept;
  logic             out_take;
  logic             out_valid_q;
  logic             skid_valid_q;
  urdd_pkg::result_t out_q, skid_q, res_new;
  urdd_pkg::bcd_t    digits;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q    <= urdd_pkg::TIMEOUT_RST;
      threshold_q  <= urdd_pkg::THRESHOLD_RST;
      left_duty_q  <= urdd_pkg::LEFT_RST;
      right_duty_q <= urdd_pkg::RIGHT_RST;
      trig_low_q   <= urdd_pkg::TRIG_LOW_RST;
      trig_high_q  <= urdd_pkg::TRIG_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        urdd_pkg::REG_TIMEOUT:   timeout_q    <= cfg_data_i;
        urdd_pkg::REG_THRESHOLD: threshold_q  <= cfg_data_i[7:0];
        urdd_pkg::REG_LEFT:      left_duty_q  <= cfg_data_i[7:0];
        urdd_pkg::REG_RIGHT:     right_duty_q <= cfg_data_i[7:0];
        urdd_pkg::REG_TRIG_LOW:  trig_low_q   <= cfg_data_i[7:0];
        urdd_pkg::REG_TRIG_HIGH: trig_high_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_q && !out_stall_i;
  assign count_inc  = count_q + 16'd1;

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    held_d  = held_q;
    done    = 1'b0;
    case (phase_q)
      urdd_pkg::PH_TRIG_LOW: begin
        count_d = count_inc;
        if (count_inc >= 16'(trig_low_q)) begin
          phase_d = urdd_pkg::PH_TRIG_HIGH;
          count_d = '0;
        end
      end
      urdd_pkg::PH_TRIG_HIGH: begin
        count_d = count_inc;
        if (count_inc >= 16'(trig_high_q)) begin
          phase_d = urdd_pkg::PH_WAIT_RISE;
          count_d = '0;
        end
      end
      urdd_pkg::PH_WAIT_RISE: begin
        if (echo_level_i) begin
          phase_d = urdd_pkg::PH_MEASURE;
          count_d = '0;
        end else if (count_q == timeout_q) begin
          held_d  = '0;
          done    = 1'b1;
          phase_d = urdd_pkg::PH_IDLE;
          count_d = '0;
        end else begin
          count_d = count_inc;
        end
      end
      urdd_pkg::PH_MEASURE: begin
        if (echo_level_i) begin
          if (count_q == timeout_q) begin
            held_d  = '0;
            done    = 1'b1;
            phase_d = urdd_pkg::PH_IDLE;
            count_d = '0;
          end else begin
            count_d = count_inc;
          end
        end else begin
          held_d  = urdd_pkg::ticks_to_cm(count_q);
          done    = 1'b1;
          phase_d = urdd_pkg::PH_IDLE;
          count_d = '0;
        end
      end
      default: begin
        // idle, and any stray code
        phase_d = urdd_pkg::PH_IDLE;
        if (start_request_i) begin
          phase_d = urdd_pkg::PH_TRIG_LOW;
          count_d = '0;
        end
      end
    endcase
  end

  always_comb begin
    digits                   = urdd_pkg::to_bcd(held_d);
    res_new.trigger_level    = (phase_d == urdd_pkg::PH_TRIG_HIGH);
    res_new.done_res         = done;
    res_new.distance_cm      = held_d;
    res_new.seg_ones         = urdd_pkg::seg_pattern(digits.ones);
    res_new.seg_tens         = urdd_pkg::seg_pattern(digits.tens);
    res_new.seg_hundreds     = urdd_pkg::seg_pattern(digits.hundreds);
    res_new.seg_thousands    = urdd_pkg::SEG_ZERO;
    res_new.left_motor_duty  = (held_d >= threshold_q) ? left_duty_q : 8'd0;
    res_new.right_motor_duty = (held_d >= threshold_q) ? right_duty_q : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= urdd_pkg::PH_IDLE;
      count_q <= '0;
      held_q  <= '0;
    end else if (in_accept) begin
      phase_q <= phase_d;
      count_q <= count_d;
      held_q  <= held_d;
    end
  end

  // Output register with one skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_take) begin
      out_valid_q  <= skid_valid_q || in_accept;
      skid_valid_q <= 1'b0;
    end else if (in_accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_take) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_accept) begin
        out_q <= res_new;
      end
    end else if (in_accept) begin
      skid_q <= res_new;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign trigger_level_o    = out_q.trigger_level;
  assign done_res_o         = out_q.done_res;
  assign distance_cm_o      = out_q.distance_cm;
  assign seg_ones_o         = out_q.seg_ones;
  assign seg_tens_o         = out_q.seg_tens;
  assign seg_hundreds_o     = out_q.seg_hundreds;
  assign seg_thousands_o    = out_q.seg_thousands;
  assign left_motor_duty_o  = out_q.left_motor_duty;
  assign right_motor_duty_o = out_q.right_motor_duty;

endmodule

`default_nettype wire

// ----- sv/urdd_checker.sv -----
// Port-level checks for the ultrasonic range display drive, bound to the top level.
`default_nettype none

module urdd_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_stall_o,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic       trigger_level_o,
  input wire logic       done_res_o,
  input wire logic [7:0] distance_cm_o,
  input wire logic [6:0] seg_ones_o,
  input wire logic [6:0] seg_tens_o,
  input wire logic [6:0] seg_hundreds_o,
  input wire logic [6:0] seg_thousands_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(distance_cm_o))
    else $error("stalled result dropped or changed");

  // Stall requests only once a result is backed up downstream
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  a_thousands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seg_thousands_o == urdd_pkg::SEG_ZERO)
    else $error("thousands digit not zero");

  a_zero_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && distance_cm_o == 8'd0 |->
      seg_ones_o == urdd_pkg::SEG_ZERO && seg_tens_o == urdd_pkg::SEG_ZERO &&
      seg_hundreds_o == urdd_pkg::SEG_ZERO)
    else $error("zero distance shows nonzero digits");

  // A finished measurement leaves the trigger low
  a_done_trig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_res_o |-> !trigger_level_o)
    else $error("trigger high on a finished measurement");

endmodule

bind ultrasonic_range_display_drive urdd_checker u_urdd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .trigger_level_o (trigger_level_o),
  .done_res_o      (done_res_o),
  .distance_cm_o   (distance_cm_o),
  .seg_ones_o      (seg_ones_o),
  .seg_tens_o      (seg_tens_o),
  .seg_hundreds_o  (seg_hundreds_o),
  .seg_thousands_o (seg_thousands_o)
);

`default_nettype wire
